FILE: src/dhlm_pkg.sv
// Shared types and constants for the diff hunk line marker.
package dhlm_pkg;

  localparam int LINE_BITS_DEF = 24;
  localparam int MARK_W        = 24;
  localparam int KIND_W        = 2;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int USED_W        = FIFO_AW + 1;

  localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MODIFIED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED  = 2'd2;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_AT    = 8'h40;

  typedef enum logic [2:0] {
    LC_START,
    LC_IGNORE,
    LC_AT,
    LC_HEADER,
    LC_PLUS1,
    LC_PLUS2,
    LC_PLUS_LINE
  } line_class_t;

  typedef enum logic [3:0] {
    HP_IDLE,
    HP_SP1,
    HP_MINUS,
    HP_OLD_START,
    HP_OLD_COUNT,
    HP_PLUS,
    HP_NEW_START,
    HP_NEW_COUNT,
    HP_AT1,
    HP_AT2,
    HP_MATCHED,
    HP_FAILED
  } header_phase_t;

  typedef struct packed {
    logic [MARK_W-1:0] line;
    logic [KIND_W-1:0] kind;
  } mark_t;

  typedef struct packed {
    logic  one;
    logic  two;
    mark_t m0;
    mark_t m1;
  } marks_t;

endpackage

FILE: src/dhlm_parser.sv
// Byte-level diff parser: line/header state and up to two marks per byte.
module dhlm_parser import dhlm_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output marks_t     marks
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  line_class_t         cls_r, cls_nxt;
  header_phase_t       ph_r, ph_nxt;
  logic                ds_r, ds_nxt;
  logic                ocn_r, ocn_nxt;
  logic                ncn_r, ncn_nxt;
  logic                ho_r, ho_nxt;
  logic                hr_r, hr_nxt;
  logic [LINE_BITS-1:0] ns_r, ns_nxt;
  logic [LINE_BITS-1:0] cur_r, cur_nxt;

  logic                 is_lf, is_at, is_plus, is_space, is_comma, is_minus, is_dig;
  logic [3:0]           dval;
  logic [LINE_BITS+3:0] ns_mul;
  logic [LINE_BITS-1:0] ns_sat;

  function automatic logic [LINE_BITS-1:0] sat_inc(input logic [LINE_BITS-1:0] v);
    return (v == LINE_MAX) ? LINE_MAX : v + 1'b1;
  endfunction

  function automatic logic [LINE_BITS-1:0] floor_dec(input logic [LINE_BITS-1:0] v);
    return (v == '0) ? '0 : v - 1'b1;
  endfunction

  function automatic logic is_plus_class(input line_class_t c);
    return (c == LC_PLUS1) || (c == LC_PLUS2) || (c == LC_PLUS_LINE);
  endfunction

  assign is_lf    = (text_byte == CH_LF);
  assign is_at    = (text_byte == CH_AT);
  assign is_plus  = (text_byte == CH_PLUS);
  assign is_space = (text_byte == CH_SPACE);
  assign is_comma = (text_byte == CH_COMMA);
  assign is_minus = (text_byte == CH_MINUS);
  assign is_dig   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign dval     = is_dig ? 4'(text_byte - CH_ZERO) : 4'd0;

  // start value times ten plus digit, saturated
  assign ns_mul = ({4'd0, ns_r} << 3) + ({4'd0, ns_r} << 1) + (LINE_BITS + 4)'(dval);
  assign ns_sat = (ns_mul[LINE_BITS+3:LINE_BITS] != 4'd0) ? LINE_MAX : ns_mul[LINE_BITS-1:0];

  // next state
  always_comb begin
    cls_nxt = cls_r;
    ph_nxt  = ph_r;
    ds_nxt  = ds_r;
    ocn_nxt = ocn_r;
    ncn_nxt = ncn_r;
    ho_nxt  = ho_r;
    hr_nxt  = hr_r;
    ns_nxt  = ns_r;
    cur_nxt = cur_r;
    if (!is_lf) begin
      unique case (cls_r)
        LC_START: begin
          if (is_at) begin
            cls_nxt = LC_AT;
          end else if (is_plus) begin
            cls_nxt = LC_PLUS1;
          end else begin
            cls_nxt = LC_IGNORE;
            if (is_space && ho_r) cur_nxt = sat_inc(cur_r);
          end
        end
        LC_AT: begin
          if (is_at) begin
            cls_nxt = LC_HEADER;
            ho_nxt  = 1'b0;
            ph_nxt  = HP_SP1;
          end else begin
            cls_nxt = LC_IGNORE;
          end
        end
        LC_HEADER: begin
          unique case (ph_r)
            HP_SP1: ph_nxt = is_space ? HP_MINUS : HP_FAILED;
            HP_MINUS: begin
              if (is_minus) begin
                ph_nxt = HP_OLD_START;
                ds_nxt = 1'b0;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            HP_OLD_START: begin
              if (is_dig) begin
                ds_nxt = 1'b1;
              end else if (is_comma && ds_r) begin
                ph_nxt  = HP_OLD_COUNT;
                ds_nxt  = 1'b0;
                ocn_nxt = 1'b0;
              end else if (is_space && ds_r) begin
                ph_nxt  = HP_PLUS;
                ocn_nxt = 1'b1;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            HP_OLD_COUNT: begin
              if (is_dig) begin
                ds_nxt = 1'b1;
                if (dval != 4'd0) ocn_nxt = 1'b1;
              end else if (is_space && ds_r) begin
                ph_nxt = HP_PLUS;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            HP_PLUS: begin
              if (is_plus) begin
                ph_nxt = HP_NEW_START;
                ds_nxt = 1'b0;
                ns_nxt = '0;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            HP_NEW_START: begin
              if (is_dig) begin
                ns_nxt = ns_sat;
                ds_nxt = 1'b1;
              end else if (is_comma && ds_r) begin
                ph_nxt  = HP_NEW_COUNT;
                ds_nxt  = 1'b0;
                ncn_nxt = 1'b0;
              end else if (is_space && ds_r) begin
                ph_nxt  = HP_AT1;
                ncn_nxt = 1'b1;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            HP_NEW_COUNT: begin
              if (is_dig) begin
                ds_nxt = 1'b1;
                if (dval != 4'd0) ncn_nxt = 1'b1;
              end else if (is_space && ds_r) begin
                ph_nxt = HP_AT1;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            HP_AT1: ph_nxt = is_at ? HP_AT2 : HP_FAILED;
            HP_AT2: begin
              if (is_at) begin
                ph_nxt  = HP_MATCHED;
                ho_nxt  = 1'b1;
                hr_nxt  = ocn_r;
                cur_nxt = ns_r;
              end else begin
                ph_nxt = HP_FAILED;
              end
            end
            default: ph_nxt = ph_r;
          endcase
        end
        LC_PLUS1: cls_nxt = is_plus ? LC_PLUS2 : LC_PLUS_LINE;
        LC_PLUS2: cls_nxt = is_plus ? LC_IGNORE : LC_PLUS_LINE;
        default: cls_nxt = cls_r;
      endcase
    end
    if (is_lf || end_of_text) begin
      if (is_plus_class(cls_nxt) && ho_nxt) cur_nxt = sat_inc(cur_nxt);
      cls_nxt = LC_START;
      ph_nxt  = HP_IDLE;
    end
    if (end_of_text) begin
      cls_nxt = LC_START;
      ph_nxt  = HP_IDLE;
      ds_nxt  = 1'b0;
      ocn_nxt = 1'b0;
      ncn_nxt = 1'b0;
      ho_nxt  = 1'b0;
      hr_nxt  = 1'b0;
      ns_nxt  = '0;
      cur_nxt = '0;
    end
  end

  // marks for the current byte
  logic  close_a, plus_after, end_b, opens, ho_after, emit_c, first;
  mark_t first_mark, c_mark;

  always_comb begin
    close_a = !is_lf && (cls_r == LC_AT) && is_at && ho_r && !ncn_r;
    if (is_lf) begin
      plus_after = is_plus_class(cls_r);
    end else begin
      plus_after = ((cls_r == LC_START) && is_plus) || (cls_r == LC_PLUS1) ||
                   ((cls_r == LC_PLUS2) && !is_plus) || (cls_r == LC_PLUS_LINE);
    end
    end_b = (is_lf || end_of_text) && plus_after && ho_r;
    opens = !is_lf && (cls_r == LC_HEADER) && (ph_r == HP_AT2) && is_at;
    if (!is_lf && (cls_r == LC_AT) && is_at) begin
      ho_after = 1'b0;
    end else begin
      ho_after = opens | ho_r;
    end
    emit_c = end_of_text && ho_after && !ncn_r;
    first  = close_a || end_b;

    c_mark.line = MARK_W'(floor_dec(ns_r));
    c_mark.kind = KIND_REMOVED;
    if (close_a) begin
      first_mark = c_mark;
    end else begin
      first_mark.line = MARK_W'(floor_dec(cur_r));
      first_mark.kind = hr_r ? KIND_MODIFIED : KIND_ADDED;
    end

    marks.one = byte_valid && (first || emit_c);
    marks.two = byte_valid && first && emit_c;
    marks.m0  = first ? first_mark : c_mark;
    marks.m1  = c_mark;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= LC_START;
      ph_r  <= HP_IDLE;
      ds_r  <= 1'b0;
      ocn_r <= 1'b0;
      ncn_r <= 1'b0;
      ho_r  <= 1'b0;
      hr_r  <= 1'b0;
      ns_r  <= '0;
      cur_r <= '0;
    end else if (byte_valid) begin
      cls_r <= cls_nxt;
      ph_r  <= ph_nxt;
      ds_r  <= ds_nxt;
      ocn_r <= ocn_nxt;
      ncn_r <= ncn_nxt;
      ho_r  <= ho_nxt;
      hr_r  <= hr_nxt;
      ns_r  <= ns_nxt;
      cur_r <= cur_nxt;
    end
  end

endmodule

FILE: src/dhlm_mark_fifo.sv
// Result queue: one entry per byte that causes marks, holding one or two marks, drained one mark per transaction.
module dhlm_mark_fifo import dhlm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  marks_t            push_marks,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [MARK_W-1:0] out_mark_line,
  output logic [KIND_W-1:0] out_mark_kind,
  output logic              out_last_of_run,
  output logic [USED_W-1:0] used
);

  marks_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic                 sel_r, sel_nxt;
  logic                 push, pop_mark, pop_entry;
  marks_t               head_e;

  assign head_e          = mem[head_r];
  assign push            = push_marks.one;
  assign out_valid       = (used_r != '0);
  assign out_mark_line   = sel_r ? head_e.m1.line : head_e.m0.line;
  assign out_mark_kind   = sel_r ? head_e.m1.kind : head_e.m0.kind;
  assign out_last_of_run = !head_e.two || sel_r;
  assign pop_mark        = out_valid && out_ready;
  assign pop_entry       = pop_mark && out_last_of_run;
  assign used            = used_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    sel_nxt  = sel_r;
    used_nxt = used_r;
    if (pop_mark) begin
      if (pop_entry) begin
        head_nxt = head_r + 1'b1;
        sel_nxt  = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
    if (push) tail_nxt = tail_r + 1'b1;
    used_nxt = used_r + USED_W'(push) - USED_W'(pop_entry);
  end

  always_ff @(posedge clk) begin
    if (push) mem[tail_r] <= push_marks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      used_r <= '0;
      sel_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      used_r <= used_nxt;
      sel_r  <= sel_nxt;
    end
  end

endmodule

FILE: src/diff_hunk_line_marker.sv
// Zero-context unified diff parser that emits new-file gutter marks.
//
// Input channel: one diff text byte per transaction (in_text_byte), with
// in_end_of_text set on the final byte of a diff. Result channel: gutter
// marks (0-based line, kind added/modified/removed-above), out_last_of_run
// set on the last mark caused by one input byte. A byte causes zero, one
// or two marks.
// Throughput: one byte per cycle sustained while in_ready is high. The byte
// is registered, parsed in the next cycle and its marks written into a
// four-entry result queue, so the first mark is valid once the queue holds
// it. A byte that causes two marks presents them one after the other.
// in_ready is driven from registered state only: it stays high while the
// queue can absorb the byte in flight and the new one. When the receiver
// stalls, the queue fills and in_ready drops once it cannot take both.
// Reset clears the parser to line start with no open hunk and empties the
// queue. The final byte of a text also returns the parser to that state.
module diff_hunk_line_marker import dhlm_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MARK_W-1:0] out_mark_line,
  output logic [KIND_W-1:0] out_mark_kind,
  output logic              out_last_of_run
);

  logic              s0_valid_r;
  logic [7:0]        s0_byte_r;
  logic              s0_eot_r;
  logic [USED_W-1:0] used;
  marks_t            marks;

  assign in_ready = (used + USED_W'(s0_valid_r)) < USED_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_byte_r <= in_text_byte;
      s0_eot_r  <= in_end_of_text;
    end
  end

  dhlm_parser #(
    .LINE_BITS(LINE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s0_valid_r),
    .text_byte  (s0_byte_r),
    .end_of_text(s0_eot_r),
    .marks      (marks)
  );

  dhlm_mark_fifo u_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .push_marks     (marks),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_mark_line  (out_mark_line),
    .out_mark_kind  (out_mark_kind),
    .out_last_of_run(out_last_of_run),
    .used           (used)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r |-> (used < USED_W'(FIFO_DEPTH)))
    else $error("result queue full with a byte in flight");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    marks.two |-> marks.one)
    else $error("second mark without a first");

  a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> out_valid)
    else $error("second mark of a pair lost");
`endif

endmodule
